@@ rtl/ttg_pkg.sv @@
// Package for the triangle tangent generator: constants, operation and status
// codes, the vertex and command structs and the back-end state type.
// No dependencies.
package ttg_pkg;

   localparam int MAX_VERTICES = 1024;
   localparam int VADDR_W      = $clog2(MAX_VERTICES);
   localparam int COUNT_W      = 11;
   localparam int IDX_W        = 12;
   localparam int NUM_COMPONENTS = 6;

   // Arithmetic widths: edges Q16.16 on 33 bits, UV deltas Q4.12 on 17 bits,
   // determinant 34 bits, products 50 bits, numerators 51 bits.
   localparam int E_W    = 33;
   localparam int D_W    = 17;
   localparam int DET_W  = 34;
   localparam int PROD_W = 50;
   localparam int NUM_W  = 51;
   localparam int QUO_W  = 33;

   localparam logic [1:0] OP_LOAD     = 2'd0;
   localparam logic [1:0] OP_TRIANGLE = 2'd1;
   localparam logic [1:0] OP_READ     = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_RANGE    = 2'd1;
   localparam logic [1:0] STATUS_ZERO_DET = 2'd2;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_READ,
      CMD_TRIANGLE,
      CMD_REPLY
   } cmd_kind_type;

   typedef logic [VADDR_W-1:0] vaddr_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [15:0] tex_u;
      logic signed [15:0] tex_v;
   } vertex_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [1:0]   status;
      vaddr_type    addr_a;
      vaddr_type    addr_b;
      vaddr_type    addr_c;
      vertex_type   vertex;
   } cmd_type;

   // Index 0..2 tangent x/y/z, 3..5 bitangent x/y/z.
   typedef logic [NUM_COMPONENTS-1:0][31:0] vec_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_FETCH_A,
      ST_FETCH_B,
      ST_FETCH_C,
      ST_FETCH_END,
      ST_DELTA,
      ST_DET_MUL,
      ST_DET_SUB,
      ST_NUM_MUL,
      ST_NUM_SUB,
      ST_DIV_START,
      ST_DIV_WAIT,
      ST_WRITE_A,
      ST_WRITE_B,
      ST_WRITE_C,
      ST_READ_WAIT,
      ST_RESULT
   } back_state_type;

endpackage

@@ rtl/triangle_tangent_generator.sv @@
// Triangle tangent generator: top level. Connects front end, command queue
// and back end. Depends on ttg_pkg, ttg_front, ttg_queue and ttg_back.
//
// Usage: write the number of loaded vertices through csr_write_en and
// csr_write_data while the block is idle. Send requests on the req_ channel
// (valid/ready): load a vertex, process a triangle or read a vertex's
// tangent frame. Every request returns exactly one response on the rsp_
// channel, in request order, with the six tangent and bitangent components
// in Q16.16 and a status code.
// A triangle is handled in steps: fetching the three corners one at a time
// from the vertex memory through its single read port, forming the edge and
// UV deltas and the determinant, running each of the six components in turn
// through the single radix-2 divider, and writing the result back to the
// tangent entries of all three corners.
// The front end takes requests into a two-entry queue, so up to two
// requests are accepted while the back end is busy.
// Reset clears the vertex count, queue, sequencer and response register;
// the vertex memories keep undefined contents until written.
// When the receiver stalls, the response is held in its register, the
// back end finishes the next request and waits, and req_ready drops once
// the queue is full.
module triangle_tangent_generator
   import ttg_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_operation,
   input  logic [IDX_W-1:0]    req_first_index,
   input  logic [IDX_W-1:0]    req_second_index,
   input  logic [IDX_W-1:0]    req_third_index,
   input  logic signed [31:0]  req_pos_x,
   input  logic signed [31:0]  req_pos_y,
   input  logic signed [31:0]  req_pos_z,
   input  logic signed [15:0]  req_tex_u,
   input  logic signed [15:0]  req_tex_v,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_tangent_x,
   output logic signed [31:0]  rsp_tangent_y,
   output logic signed [31:0]  rsp_tangent_z,
   output logic signed [31:0]  rsp_bitangent_x,
   output logic signed [31:0]  rsp_bitangent_y,
   output logic signed [31:0]  rsp_bitangent_z,
   output logic [1:0]          rsp_status,
   input  logic                csr_write_en,
   input  logic [COUNT_W-1:0]  csr_write_data
);

   logic    q_push, q_full, q_pop, q_empty;
   cmd_type q_data, q_head;
   vec_type rsp_vec;

   ttg_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_first_index  (req_first_index),
      .req_second_index (req_second_index),
      .req_third_index  (req_third_index),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_pos_z        (req_pos_z),
      .req_tex_u        (req_tex_u),
      .req_tex_v        (req_tex_v),
      .csr_write_en     (csr_write_en),
      .csr_write_data   (csr_write_data),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_data           (q_data)
   );

   ttg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .head      (q_head)
   );

   ttg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_vec    (rsp_vec),
      .rsp_status (rsp_status)
   );

   assign rsp_tangent_x   = rsp_vec[0];
   assign rsp_tangent_y   = rsp_vec[1];
   assign rsp_tangent_z   = rsp_vec[2];
   assign rsp_bitangent_x = rsp_vec[3];
   assign rsp_bitangent_y = rsp_vec[4];
   assign rsp_bitangent_z = rsp_vec[5];

endmodule

@@ rtl/ttg_queue.sv @@
// Two-entry command queue between the front end and the back end.
// Depends on ttg_pkg.
module ttg_queue
   import ttg_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    empty,
   output cmd_type head
);

   cmd_type    entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full  = (count_ff == 2'd2);
   assign empty = (count_ff == 2'd0);
   assign head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/ttg_front.sv @@
// Front end: holds the vertex count register, range-checks and classifies
// each request and pushes a command into the queue. Depends on ttg_pkg.
module ttg_front
   import ttg_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_operation,
   input  logic [IDX_W-1:0]           req_first_index,
   input  logic [IDX_W-1:0]           req_second_index,
   input  logic [IDX_W-1:0]           req_third_index,
   input  logic signed [31:0]         req_pos_x,
   input  logic signed [31:0]         req_pos_y,
   input  logic signed [31:0]         req_pos_z,
   input  logic signed [15:0]         req_tex_u,
   input  logic signed [15:0]         req_tex_v,
   input  logic                       csr_write_en,
   input  logic [COUNT_W-1:0]         csr_write_data,
   input  logic                       q_full,
   output logic                       q_push,
   output cmd_type                    q_data
);

   logic [COUNT_W-1:0] vertex_count_ff, vertex_count_in;
   logic               ok_a, ok_b, ok_c;

   function automatic logic in_range(input logic [IDX_W-1:0] idx,
                                     input logic [COUNT_W-1:0] cnt);
      logic [IDX_W:0] wide;
      wide = {1'b0, idx};
      return (wide < (IDX_W+1)'(cnt)) && (wide < (IDX_W+1)'(MAX_VERTICES));
   endfunction

   assign vertex_count_in = csr_write_en ? csr_write_data : vertex_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= '0;
      end else begin
         vertex_count_ff <= vertex_count_in;
      end
   end

   assign ok_a = in_range(req_first_index, vertex_count_ff);
   assign ok_b = in_range(req_second_index, vertex_count_ff);
   assign ok_c = in_range(req_third_index, vertex_count_ff);

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      q_data               = '0;
      q_data.addr_a        = req_first_index[VADDR_W-1:0];
      q_data.addr_b        = req_second_index[VADDR_W-1:0];
      q_data.addr_c        = req_third_index[VADDR_W-1:0];
      q_data.vertex.pos_x  = req_pos_x;
      q_data.vertex.pos_y  = req_pos_y;
      q_data.vertex.pos_z  = req_pos_z;
      q_data.vertex.tex_u  = req_tex_u;
      q_data.vertex.tex_v  = req_tex_v;
      q_data.status        = STATUS_OK;
      q_data.kind          = CMD_REPLY;
      unique case (req_operation)
         OP_LOAD: begin
            q_data.kind   = ok_a ? CMD_LOAD : CMD_REPLY;
            q_data.status = ok_a ? STATUS_OK : STATUS_RANGE;
         end
         OP_READ: begin
            q_data.kind   = ok_a ? CMD_READ : CMD_REPLY;
            q_data.status = ok_a ? STATUS_OK : STATUS_RANGE;
         end
         OP_TRIANGLE: begin
            q_data.kind   = (ok_a && ok_b && ok_c) ? CMD_TRIANGLE : CMD_REPLY;
            q_data.status = (ok_a && ok_b && ok_c) ? STATUS_OK : STATUS_RANGE;
         end
         default: begin
            q_data.kind   = CMD_REPLY;
            q_data.status = STATUS_OK;
         end
      endcase
   end

endmodule

@@ rtl/ttg_div.sv @@
// Radix-2 restoring divider: round(num * 2^12 / den), ties away from zero,
// saturated to signed 32 bits. Depends on ttg_pkg.
module ttg_div
   import ttg_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [NUM_W-1:0] num,
   input  logic signed [DET_W-1:0] den,
   output logic                    done,
   output logic [31:0]             result
);

   localparam int BIG_W = NUM_W + 14;
   localparam int CNT_W = $clog2(QUO_W + 1);

   logic               busy_ff, busy_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic               zero_ff, zero_in;
   logic               ovf_ff, ovf_in;
   logic [DET_W:0]     dvs_ff, dvs_in;
   logic [DET_W:0]     rem_ff, rem_in;
   logic [QUO_W-1:0]   low_ff, low_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;

   logic [NUM_W-1:0]   n_abs;
   logic [DET_W-1:0]   d_abs;
   logic [BIG_W-1:0]   big;
   logic [DET_W:0]     dvs_new;
   logic [DET_W+1:0]   trial;
   logic               ge;

   assign n_abs   = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
   assign d_abs   = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);
   // Rounding to nearest: floor((n * 2^13 + d) / (2 * d)).
   assign big     = BIG_W'({n_abs, 13'b0}) + BIG_W'(d_abs);
   assign dvs_new = {d_abs, 1'b0};

   assign trial = {rem_ff, low_ff[QUO_W-1]};
   assign ge    = (trial >= {1'b0, dvs_ff});

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      ovf_in  = ovf_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QUO_W);
         neg_in  = num[NUM_W-1] ^ den[DET_W-1];
         zero_in = (n_abs == '0) || (d_abs == '0);
         // A quotient of 2^33 or more saturates whatever its low bits are.
         ovf_in  = (DET_W+1)'(big[BIG_W-1:QUO_W]) >= dvs_new;
         dvs_in  = dvs_new;
         rem_in  = (DET_W+1)'(big[BIG_W-1:QUO_W]);
         low_in  = big[QUO_W-1:0];
         quo_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            cnt_in = cnt_ff - CNT_W'(1);
            rem_in = ge ? (DET_W+1)'(trial - {1'b0, dvs_ff}) : (DET_W+1)'(trial);
            low_in = {low_ff[QUO_W-2:0], 1'b0};
            quo_in = {quo_ff[QUO_W-2:0], ge};
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      ovf_ff  <= ovf_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quo_ff  <= quo_in;
   end

   assign done = busy_ff && (cnt_ff == '0);

   always_comb begin
      if (zero_ff) begin
         result = '0;
      end else if (neg_ff) begin
         if (ovf_ff || (quo_ff > QUO_W'(33'h0_8000_0000))) begin
            result = 32'h8000_0000;
         end else begin
            result = ~quo_ff[31:0] + 32'd1;
         end
      end else begin
         if (ovf_ff || (quo_ff > QUO_W'(33'h0_7FFF_FFFF))) begin
            result = 32'h7FFF_FFFF;
         end else begin
            result = quo_ff[31:0];
         end
      end
   end

endmodule

@@ rtl/ttg_back.sv @@
// Back end: vertex and tangent memories, the triangle sequencer with its
// multipliers, the shared divider and the result register.
// Depends on ttg_pkg and ttg_div.
module ttg_back
   import ttg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  cmd_type    q_head,
   output logic       q_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output vec_type    rsp_vec,
   output logic [1:0] rsp_status
);

   back_state_type state_ff, state_in;

   vertex_type vtx_mem [MAX_VERTICES];
   vec_type    tan_mem [MAX_VERTICES];
   vertex_type vtx_rd_ff;
   vec_type    tan_rd_ff;

   logic       vtx_we;
   vaddr_type  vtx_raddr;
   logic       tan_we;
   vaddr_type  tan_waddr;
   vec_type    tan_wdata;
   vaddr_type  tan_raddr;
   logic       div_start;
   logic       div_done;
   logic [31:0] div_result;
   logic       out_free;

   vaddr_type               a_ff, a_in, b_ff, b_in, c_ff, c_in;
   vertex_type              vtx_ff [3];
   vertex_type              vtx_in [3];
   logic signed [E_W-1:0]   e1_ff [3];
   logic signed [E_W-1:0]   e1_in [3];
   logic signed [E_W-1:0]   e2_ff [3];
   logic signed [E_W-1:0]   e2_in [3];
   logic signed [D_W-1:0]   du1_ff, du1_in, dv1_ff, dv1_in;
   logic signed [D_W-1:0]   du2_ff, du2_in, dv2_ff, dv2_in;
   logic signed [DET_W-1:0] dpa_ff, dpa_in, dpb_ff, dpb_in;
   logic signed [DET_W-1:0] det_ff, det_in, det_diff;
   logic signed [PROD_W-1:0] pa_ff, pa_in, pb_ff, pb_in;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic [2:0]              comp_ff, comp_in;
   logic [1:0]              axis;
   logic signed [D_W-1:0]   coef_a, coef_b;
   logic signed [E_W-1:0]   edge_a, edge_b;
   vec_type                 res_ff, res_in;
   logic [1:0]              status_ff, status_in;
   logic                    out_valid_ff, out_valid_in;
   vec_type                 out_vec_ff, out_vec_in;
   logic [1:0]              out_status_ff, out_status_in;

   function automatic logic signed [31:0] pos_of(input vertex_type v, input int k);
      logic signed [31:0] p;
      unique case (k)
         0:       p = v.pos_x;
         1:       p = v.pos_y;
         default: p = v.pos_z;
      endcase
      return p;
   endfunction

   // Memories.
   always_ff @(posedge clock) begin
      if (vtx_we) begin
         vtx_mem[q_head.addr_a] <= q_head.vertex;
      end
      vtx_rd_ff <= vtx_mem[vtx_raddr];
   end

   always_ff @(posedge clock) begin
      if (tan_we) begin
         tan_mem[tan_waddr] <= tan_wdata;
      end
      tan_rd_ff <= tan_mem[tan_raddr];
   end

   ttg_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .num    (num_ff),
      .den    (det_ff),
      .done   (div_done),
      .result (div_result)
   );

   assign out_free = !out_valid_ff || rsp_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               unique case (q_head.kind)
                  CMD_READ:     state_in = ST_READ_WAIT;
                  CMD_TRIANGLE: state_in = ST_FETCH_A;
                  default:      state_in = ST_RESULT;
               endcase
            end
         end
         ST_FETCH_A:   state_in = ST_FETCH_B;
         ST_FETCH_B:   state_in = ST_FETCH_C;
         ST_FETCH_C:   state_in = ST_FETCH_END;
         ST_FETCH_END: state_in = ST_DELTA;
         ST_DELTA:     state_in = ST_DET_MUL;
         ST_DET_MUL:   state_in = ST_DET_SUB;
         ST_DET_SUB:   state_in = ST_NUM_MUL;
         ST_NUM_MUL:   state_in = ST_NUM_SUB;
         ST_NUM_SUB:   state_in = ST_DIV_START;
         ST_DIV_START: state_in = ST_DIV_WAIT;
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = (comp_ff == 3'(NUM_COMPONENTS - 1)) ? ST_WRITE_A : ST_NUM_MUL;
            end
         end
         ST_WRITE_A:   state_in = ST_WRITE_B;
         ST_WRITE_B:   state_in = ST_WRITE_C;
         ST_WRITE_C:   state_in = ST_RESULT;
         ST_READ_WAIT: state_in = ST_RESULT;
         ST_RESULT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   // Control outputs.
   always_comb begin
      q_pop     = 1'b0;
      vtx_we    = 1'b0;
      vtx_raddr = a_ff;
      tan_we    = 1'b0;
      tan_waddr = a_ff;
      tan_wdata = res_ff;
      tan_raddr = q_head.addr_a;
      div_start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            q_pop = !q_empty;
            if (!q_empty && (q_head.kind == CMD_LOAD)) begin
               // A load also clears the vertex's tangent frame.
               vtx_we    = 1'b1;
               tan_we    = 1'b1;
               tan_waddr = q_head.addr_a;
               tan_wdata = '0;
            end
         end
         ST_FETCH_A:   vtx_raddr = a_ff;
         ST_FETCH_B:   vtx_raddr = b_ff;
         ST_FETCH_C:   vtx_raddr = c_ff;
         ST_DIV_START: div_start = 1'b1;
         ST_WRITE_A: begin
            tan_we    = 1'b1;
            tan_waddr = a_ff;
         end
         ST_WRITE_B: begin
            tan_we    = 1'b1;
            tan_waddr = b_ff;
         end
         ST_WRITE_C: begin
            tan_we    = 1'b1;
            tan_waddr = c_ff;
         end
         default: begin
         end
      endcase
   end

   // Component 0..2 is the tangent, 3..5 the bitangent, on axis x, y, z.
   always_comb begin
      axis = (comp_ff < 3'd3) ? comp_ff[1:0] : 2'(comp_ff - 3'd3);
      if (comp_ff < 3'd3) begin
         coef_a = dv2_ff;
         edge_a = e1_ff[axis];
         coef_b = dv1_ff;
         edge_b = e2_ff[axis];
      end else begin
         coef_a = du1_ff;
         edge_a = e2_ff[axis];
         coef_b = du2_ff;
         edge_b = e1_ff[axis];
      end
   end

   assign det_diff = dpa_ff - dpb_ff;

   // Datapath.
   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      vtx_in    = vtx_ff;
      e1_in     = e1_ff;
      e2_in     = e2_ff;
      du1_in    = du1_ff;
      dv1_in    = dv1_ff;
      du2_in    = du2_ff;
      dv2_in    = dv2_ff;
      dpa_in    = dpa_ff;
      dpb_in    = dpb_ff;
      det_in    = det_ff;
      pa_in     = pa_ff;
      pb_in     = pb_ff;
      num_in    = num_ff;
      comp_in   = comp_ff;
      res_in    = res_ff;
      status_in = status_ff;
      unique case (state_ff)
         ST_IDLE: begin
            a_in      = q_head.addr_a;
            b_in      = q_head.addr_b;
            c_in      = q_head.addr_c;
            res_in    = '0;
            status_in = (q_head.kind == CMD_REPLY) ? q_head.status : STATUS_OK;
         end
         ST_FETCH_B:   vtx_in[0] = vtx_rd_ff;
         ST_FETCH_C:   vtx_in[1] = vtx_rd_ff;
         ST_FETCH_END: vtx_in[2] = vtx_rd_ff;
         ST_DELTA: begin
            for (int k = 0; k < 3; k++) begin
               e1_in[k] = E_W'(pos_of(vtx_ff[1], k)) - E_W'(pos_of(vtx_ff[0], k));
               e2_in[k] = E_W'(pos_of(vtx_ff[2], k)) - E_W'(pos_of(vtx_ff[0], k));
            end
            du1_in = {vtx_ff[1].tex_u[15], vtx_ff[1].tex_u}
                   - {vtx_ff[0].tex_u[15], vtx_ff[0].tex_u};
            dv1_in = {vtx_ff[1].tex_v[15], vtx_ff[1].tex_v}
                   - {vtx_ff[0].tex_v[15], vtx_ff[0].tex_v};
            du2_in = {vtx_ff[2].tex_u[15], vtx_ff[2].tex_u}
                   - {vtx_ff[0].tex_u[15], vtx_ff[0].tex_u};
            dv2_in = {vtx_ff[2].tex_v[15], vtx_ff[2].tex_v}
                   - {vtx_ff[0].tex_v[15], vtx_ff[0].tex_v};
         end
         ST_DET_MUL: begin
            dpa_in = du1_ff * dv2_ff;
            dpb_in = du2_ff * dv1_ff;
         end
         ST_DET_SUB: begin
            det_in    = det_diff;
            status_in = (det_diff == '0) ? STATUS_ZERO_DET : STATUS_OK;
            comp_in   = '0;
         end
         ST_NUM_MUL: begin
            pa_in = coef_a * edge_a;
            pb_in = coef_b * edge_b;
         end
         ST_NUM_SUB: begin
            num_in = {pa_ff[PROD_W-1], pa_ff} - {pb_ff[PROD_W-1], pb_ff};
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               res_in[comp_ff] = div_result;
               comp_in         = comp_ff + 3'd1;
            end
         end
         ST_READ_WAIT: res_in = tan_rd_ff;
         default: begin
         end
      endcase
   end

   // Result register: holds one result while the back end works on the next.
   always_comb begin
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_vec_in    = out_vec_ff;
      out_status_in = out_status_ff;
      if ((state_ff == ST_RESULT) && out_free) begin
         out_valid_in  = 1'b1;
         out_vec_in    = res_ff;
         out_status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff          <= a_in;
      b_ff          <= b_in;
      c_ff          <= c_in;
      vtx_ff        <= vtx_in;
      e1_ff         <= e1_in;
      e2_ff         <= e2_in;
      du1_ff        <= du1_in;
      dv1_ff        <= dv1_in;
      du2_ff        <= du2_in;
      dv2_ff        <= dv2_in;
      dpa_ff        <= dpa_in;
      dpb_ff        <= dpb_in;
      det_ff        <= det_in;
      pa_ff         <= pa_in;
      pb_ff         <= pb_in;
      num_ff        <= num_in;
      comp_ff       <= comp_in;
      res_ff        <= res_in;
      status_ff     <= status_in;
      out_vec_ff    <= out_vec_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_vec    = out_vec_ff;
   assign rsp_status = out_status_ff;

endmodule

@@ rtl/ttg_checker.sv @@
// Port-level checks for the triangle tangent generator, bound to the top
// level. Depends on ttg_pkg.
module ttg_port_checker
   import ttg_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_tangent_x,
   input logic signed [31:0] rsp_tangent_y,
   input logic signed [31:0] rsp_tangent_z,
   input logic signed [31:0] rsp_bitangent_x,
   input logic signed [31:0] rsp_bitangent_y,
   input logic signed [31:0] rsp_bitangent_z,
   input logic [1:0]         rsp_status
);

   // A stalled response stays up.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // A stalled response keeps its status, tangent x and bitangent z.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_tangent_x)
                                  && $stable(rsp_bitangent_z))
      else $error("response payload changed while stalled");

   // Rejected requests and degenerate UV mappings carry a zero frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_RANGE || rsp_status == STATUS_ZERO_DET)
      |-> rsp_tangent_x == 0 && rsp_tangent_y == 0 && rsp_tangent_z == 0
          && rsp_bitangent_x == 0 && rsp_bitangent_y == 0 && rsp_bitangent_z == 0)
      else $error("nonzero frame with error status");

   // Nothing is presented right after reset.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind triangle_tangent_generator ttg_port_checker u_ttg_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_tangent_x   (rsp_tangent_x),
   .rsp_tangent_y   (rsp_tangent_y),
   .rsp_tangent_z   (rsp_tangent_z),
   .rsp_bitangent_x (rsp_bitangent_x),
   .rsp_bitangent_y (rsp_bitangent_y),
   .rsp_bitangent_z (rsp_bitangent_z),
   .rsp_status      (rsp_status)
);
